@@ hdl/dlps_pkg.sv @@
// Shared types and constants for the decimal literal prefix scanner.
package dlps_pkg;

  localparam int unsigned MAX_TOKEN_LEN_DEF = 255;
  localparam int unsigned LEN_W_MAX = 16;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_LOW_E = 8'h65;
  localparam logic [7:0] CH_UP_E  = 8'h45;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  typedef enum logic [1:0] {
    ST_NAN   = 2'd0,
    ST_TRAIL = 2'd1,
    ST_WHOLE = 2'd2,
    ST_LONG  = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } scan_in_t;

  typedef struct packed {
    logic [7:0] prefix_length;
    status_t    status;
  } scan_out_t;

endpackage

@@ hdl/dlps_scan.sv @@
// Per-character scan state and the result produced on the last character.
module dlps_scan import dlps_pkg::*; #(
  parameter int unsigned MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      take,
  input  scan_in_t  word,
  output logic      done,
  output scan_out_t result
);

  localparam int unsigned PW = $clog2(MAX_TOKEN_LEN + 1);

  typedef enum logic [2:0] {
    PH_INT      = 3'd0,
    PH_FRAC     = 3'd1,
    PH_EXP_MARK = 3'd2,
    PH_EXP_SIGN = 3'd3,
    PH_EXP_DIG  = 3'd4,
    PH_JUNK     = 3'd5
  } phase_t;

  phase_t          scan_phase, scan_phase_next;
  logic [PW-1:0]   char_position, char_position_next;
  logic            mantissa_seen, mantissa_seen_next;
  logic [PW-1:0]   literal_end, literal_end_next;
  logic            length_overflow, length_overflow_next;

  logic            full;
  logic            dig;
  logic            is_e;
  logic [LEN_W_MAX:0] end_ext;

  assign full = char_position >= PW'(MAX_TOKEN_LEN);
  assign dig  = (word.character >= CH_ZERO) && (word.character <= CH_NINE);
  assign is_e = (word.character == CH_LOW_E) || (word.character == CH_UP_E);

  always_comb begin
    scan_phase_next      = scan_phase;
    char_position_next   = char_position;
    mantissa_seen_next   = mantissa_seen;
    literal_end_next     = literal_end;
    length_overflow_next = length_overflow;
    if (full) begin
      length_overflow_next = 1'b1;
    end else begin
      char_position_next = char_position + PW'(1);
      case (scan_phase)
        PH_INT: begin
          if (dig) begin
            mantissa_seen_next = 1'b1;
            literal_end_next   = char_position_next;
          end else if (word.character == CH_DOT) begin
            if (mantissa_seen) begin
              literal_end_next = char_position_next;
            end
            scan_phase_next = PH_FRAC;
          end else if (is_e && mantissa_seen) begin
            scan_phase_next = PH_EXP_MARK;
          end else begin
            scan_phase_next = PH_JUNK;
          end
        end
        PH_FRAC: begin
          if (dig) begin
            mantissa_seen_next = 1'b1;
            literal_end_next   = char_position_next;
          end else if (is_e && mantissa_seen) begin
            scan_phase_next = PH_EXP_MARK;
          end else begin
            scan_phase_next = PH_JUNK;
          end
        end
        PH_EXP_MARK: begin
          if (dig) begin
            literal_end_next = char_position_next;
            scan_phase_next  = PH_EXP_DIG;
          end else if (word.character == CH_PLUS || word.character == CH_MINUS) begin
            scan_phase_next = PH_EXP_SIGN;
          end else begin
            scan_phase_next = PH_JUNK;
          end
        end
        PH_EXP_SIGN, PH_EXP_DIG: begin
          if (dig) begin
            literal_end_next = char_position_next;
            scan_phase_next  = PH_EXP_DIG;
          end else begin
            scan_phase_next = PH_JUNK;
          end
        end
        default: begin
          scan_phase_next = PH_JUNK;
        end
      endcase
    end
  end

  assign end_ext = (LEN_W_MAX + 1)'(literal_end_next);

  always_comb begin
    done = take && word.last;
    result.prefix_length = (end_ext > (LEN_W_MAX + 1)'(255)) ? 8'hFF : end_ext[7:0];
    if (length_overflow_next) begin
      result.status = ST_LONG;
    end else if (literal_end_next == '0) begin
      result.status = ST_NAN;
    end else if (literal_end_next != char_position_next) begin
      result.status = ST_TRAIL;
    end else begin
      result.status = ST_WHOLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && word.last)) begin
      scan_phase      <= PH_INT;
      char_position   <= '0;
      mantissa_seen   <= 1'b0;
      literal_end     <= '0;
      length_overflow <= 1'b0;
    end else if (take) begin
      scan_phase      <= scan_phase_next;
      char_position   <= char_position_next;
      mantissa_seen   <= mantissa_seen_next;
      literal_end     <= literal_end_next;
      length_overflow <= length_overflow_next;
    end
  end

endmodule

@@ hdl/dlps_outbuf.sv @@
// Result register between the scanner and the result channel.
module dlps_outbuf import dlps_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  scan_out_t load_word,
  output logic      busy,
  output logic      valid,
  input  logic      stall,
  output scan_out_t word
);

  assign busy = valid && stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word <= load_word;
    end
  end

endmodule

@@ hdl/decimal_literal_prefix_scanner_core.sv @@
// Decimal literal prefix scanner: one character word per unstalled cycle, one result word
// per token. A token arrives as character words; the word with last set closes it and yields
// one result word (prefix_length, status) in the result register in the next cycle. Words
// with last clear yield nothing. The scanner takes a new character every cycle the result
// register is empty or being emptied, so a stalled result holds off the character channel
// only while a finished result is still waiting. Characters beyond MAX_TOKEN_LEN are taken
// and ignored, and the token reports status "too long"; prefix_length saturates at 255.
module decimal_literal_prefix_scanner_core import dlps_pkg::*; #(
  parameter int unsigned MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      char_valid,
  output logic      char_stall,
  input  scan_in_t  char_word,
  output logic      result_valid,
  input  logic      result_stall,
  output scan_out_t result_word
);

  logic      take;
  logic      done;
  scan_out_t result;

  assign take = char_valid && !char_stall;

  dlps_scan #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .word   (char_word),
    .done   (done),
    .result (result)
  );

  dlps_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .load      (done),
    .load_word (result),
    .busy      (char_stall),
    .valid     (result_valid),
    .stall     (result_stall),
    .word      (result_word)
  );

endmodule
